>>> design/pidpi_pkg.sv
// ---------------------------------------------------------------------------
// pidpi_pkg: shared types and arithmetic for the PID controller
// Register codes, configuration/state/result structs, saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package pidpi_pkg;

  localparam int ErrW      = 16;
  localparam int GainW     = 16;
  localparam int DataW     = 32;
  localparam int LimitW    = 31;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 31;

  typedef enum logic [CfgIndexW-1:0] {
    REG_MODE      = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_INT_LIMIT = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } pid_mode_t;

  typedef struct packed {
    pid_mode_t                 mode;
    logic signed [GainW-1:0]   gain_p;
    logic signed [GainW-1:0]   gain_i;
    logic signed [GainW-1:0]   gain_d;
    logic        [LimitW-1:0]  integral_limit;
  } pid_cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0]   integral_sum;
    logic signed [ErrW-1:0]    previous_error;
    logic signed [ErrW:0]      previous_difference;
    logic signed [DataW-1:0]   running_output;
  } pid_state_t;

  typedef struct packed {
    logic signed [DataW-1:0]   control_out;
    logic signed [DataW-1:0]   p_term;
    logic signed [DataW-1:0]   i_term;
    logic signed [DataW-1:0]   d_term;
  } pid_result_t;

  localparam logic signed [DataW-1:0] S32Max = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] S32Min = {1'b1, {(DataW-1){1'b0}}};

  // saturate a 34-bit signed sum to 32 bits
  function automatic logic signed [DataW-1:0] sat34(input logic signed [DataW+1:0] x);
    logic signed [DataW-1:0] r;
    if ((x[DataW+1:DataW-1] == 3'b000) || (x[DataW+1:DataW-1] == 3'b111)) begin
      r = x[DataW-1:0];
    end else begin
      r = x[DataW+1] ? S32Min : S32Max;
    end
    return r;
  endfunction

  // Q8.8 gain times value, floor shift by 8, saturate to 32 bits
  function automatic logic signed [DataW-1:0] gain_mul(input logic signed [GainW-1:0] g,
                                                        input logic signed [DataW-1:0] v);
    logic signed [GainW+DataW-1:0] prod;
    logic signed [DataW-1:0]       r;
    prod = g * v;
    if ((prod[GainW+DataW-1:DataW+7] == '0) || (prod[GainW+DataW-1:DataW+7] == '1)) begin
      r = prod[DataW+7:8];
    end else begin
      r = prod[GainW+DataW-1] ? S32Min : S32Max;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/pid_position_incremental.sv
// Path: an accepted request is held in the input register (err_r), and its
//   result is registered into result_r when it advances, then shown on out_*.
// Throughput: one request per cycle while the output is not stalled; the
//   controller state loop closes through the combinational datapath between the input and result registers.
// Reset (rst_n low, synchronous): configuration, integrator, previous error,
//   previous difference and running output clear to zero; both stages empty.
// ---------------------------------------------------------------------------
// pid_position_incremental: positional / incremental PID controller
// One signed error sample in, drive value and P/I/D terms out.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_position_incremental (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [pidpi_pkg::CfgIndexW-1:0]     cfg_index,
  input  wire logic [pidpi_pkg::CfgDataW-1:0]      cfg_data,
  // error sample requests
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [pidpi_pkg::ErrW-1:0]   in_error_sample,
  // result requests
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [pidpi_pkg::DataW-1:0]       out_control_out,
  output logic signed [pidpi_pkg::DataW-1:0]       out_p_term,
  output logic signed [pidpi_pkg::DataW-1:0]       out_i_term,
  output logic signed [pidpi_pkg::DataW-1:0]       out_d_term
);

  pidpi_pkg::pid_cfg_t     cfg;
  pidpi_pkg::pid_state_t   state_r;
  pidpi_pkg::pid_state_t   state_nxt;
  pidpi_pkg::pid_result_t  result_nxt;
  pidpi_pkg::pid_result_t  result_r;

  logic                              in_vld_r;
  logic signed [pidpi_pkg::ErrW-1:0] err_r;
  logic                              out_vld_r;
  logic                              advance;
  logic                              in_take;

  pidpi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input stage moves into the result register when that one is empty or
  // being drained this cycle. The state commits on the same move, so each
  // request updates the controller exactly once.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  pidpi_datapath u_dp (
    .cfg          (cfg),
    .state        (state_r),
    .error_sample (err_r),
    .state_nxt    (state_nxt),
    .result       (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      err_r <= in_error_sample;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_control_out = result_r.control_out;
  assign out_p_term      = result_r.p_term;
  assign out_i_term      = result_r.i_term;
  assign out_d_term      = result_r.d_term;

endmodule

`default_nettype wire

>>> design/pidpi_cfg.sv
// ---------------------------------------------------------------------------
// pidpi_cfg: configuration register file
// Write-only registers decoded by index; unknown indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module pidpi_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [pidpi_pkg::CfgIndexW-1:0]    cfg_index,
  input  wire logic [pidpi_pkg::CfgDataW-1:0]     cfg_data,
  output pidpi_pkg::pid_cfg_t                     cfg
);

  pidpi_pkg::pid_cfg_t cfg_r;
  pidpi_pkg::pid_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (pidpi_pkg::cfg_reg_t'(cfg_index))
        pidpi_pkg::REG_MODE:      cfg_nxt.mode = pidpi_pkg::pid_mode_t'(cfg_data[0]);
        pidpi_pkg::REG_GAIN_P:    cfg_nxt.gain_p = cfg_data[pidpi_pkg::GainW-1:0];
        pidpi_pkg::REG_GAIN_I:    cfg_nxt.gain_i = cfg_data[pidpi_pkg::GainW-1:0];
        pidpi_pkg::REG_GAIN_D:    cfg_nxt.gain_d = cfg_data[pidpi_pkg::GainW-1:0];
        pidpi_pkg::REG_INT_LIMIT: cfg_nxt.integral_limit = cfg_data[pidpi_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> design/pidpi_datapath.sv
// ---------------------------------------------------------------------------
// pidpi_datapath: one PID step
// Forms the three terms with shared multipliers, the drive value and the
// next controller state from the registered error sample.
// ---------------------------------------------------------------------------
`default_nettype none

module pidpi_datapath (
  input  wire pidpi_pkg::pid_cfg_t                cfg,
  input  wire pidpi_pkg::pid_state_t              state,
  input  wire logic signed [pidpi_pkg::ErrW-1:0]  error_sample,
  output pidpi_pkg::pid_state_t                   state_nxt,
  output pidpi_pkg::pid_result_t                  result
);

  localparam int DW = pidpi_pkg::DataW;
  localparam int EW = pidpi_pkg::ErrW;

  logic signed [EW:0]    diff;        // first difference
  logic signed [EW+1:0]  diff2;       // second difference
  logic signed [DW:0]    acc_raw;
  logic signed [DW-1:0]  acc_sat;
  logic signed [DW:0]    acc_w;
  logic signed [DW:0]    lim_pos;
  logic signed [DW:0]    lim_neg;
  logic signed [DW-1:0]  integ_new;
  logic signed [DW-1:0]  op_p, op_i, op_d;
  logic signed [DW-1:0]  p, i, d;
  logic signed [DW+1:0]  sum;
  logic                  incr;

  always_comb begin
    incr  = (cfg.mode == pidpi_pkg::MODE_INCREMENTAL);
    diff  = (EW+1)'(error_sample) - (EW+1)'(state.previous_error);
    diff2 = (EW+2)'(diff) - (EW+2)'(state.previous_difference);

    // positional integrator: saturate, then clamp to +/- limit
    acc_raw = (DW+1)'(state.integral_sum) + (DW+1)'(error_sample);
    acc_sat = pidpi_pkg::sat34((DW+2)'(acc_raw));
    acc_w   = (DW+1)'(acc_sat);
    lim_pos = signed'({2'b00, cfg.integral_limit});
    lim_neg = -lim_pos;
    if (acc_w > lim_pos) begin
      integ_new = lim_pos[DW-1:0];
    end else if (acc_w < lim_neg) begin
      integ_new = lim_neg[DW-1:0];
    end else begin
      integ_new = acc_sat;
    end

    // operand steering so each gain has one multiplier
    op_p = incr ? DW'(diff)         : DW'(error_sample);
    op_i = incr ? DW'(error_sample) : integ_new;
    op_d = incr ? DW'(diff2)        : DW'(diff);

    p = pidpi_pkg::gain_mul(cfg.gain_p, op_p);
    i = pidpi_pkg::gain_mul(cfg.gain_i, op_i);
    d = pidpi_pkg::gain_mul(cfg.gain_d, op_d);

    sum = (DW+2)'(p) + (DW+2)'(i) + (DW+2)'(d)
        + (incr ? (DW+2)'(state.running_output) : '0);

    result.control_out = pidpi_pkg::sat34(sum);
    result.p_term      = p;
    result.i_term      = i;
    result.d_term      = d;

    state_nxt.integral_sum        = incr ? state.integral_sum : integ_new;
    state_nxt.previous_difference = incr ? diff : state.previous_difference;
    state_nxt.previous_error      = error_sample;
    state_nxt.running_output      = result.control_out;
  end

endmodule

`default_nettype wire

>>> design/pidpi_checker.sv
// ---------------------------------------------------------------------------
// pidpi_checker: port-level checks for the PID controller
// Watches the request handshakes on the top level and binds to it.
// ---------------------------------------------------------------------------
`default_nettype none

module pidpi_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [pidpi_pkg::DataW-1:0]  out_control_out
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_control_out))
    else $error("result changed while stalled");

  // input only backs up when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room downstream");

  // a fresh result traces back to an accepted request through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching request");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pid_position_incremental pidpi_checker u_pidpi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_control_out (out_control_out)
);

`default_nettype wire
